// ----- sv/bdd_ut_pkg.sv -----
`default_nettype none

package bdd_ut_pkg;

    // field widths of the key and result
    localparam int VAR_W     = 8;
    localparam int CHILD_W   = 12;
    localparam int NODE_ID_W = 12;

    // store sizing
    localparam int MAX_NODES   = 4096;
    localparam int BUCKET_BITS = 8;
    localparam int NUM_BUCKETS = 1 << BUCKET_BITS;
    localparam int VAR_BITS    = 8;

    localparam int ID_BITS    = $clog2(MAX_NODES);
    localparam int COUNT_BITS = $clog2(MAX_NODES + 1);
    localparam int HASH_W     = (VAR_BITS > CHILD_W) ? VAR_BITS : CHILD_W;

    // stream widths
    localparam int IN_DATA_W  = ((VAR_W + 2 * CHILD_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((NODE_ID_W + 7) / 8) * 8;
    localparam int OUT_USER_W = 2;

    typedef logic [ID_BITS-1:0]     node_idx_t;
    typedef logic [BUCKET_BITS-1:0] bucket_t;

    // one node store word
    typedef struct packed {
        logic                 next_valid;
        node_idx_t            next_idx;
        logic [CHILD_W-1:0]   low;
        logic [CHILD_W-1:0]   high;
        logic [VAR_BITS-1:0]  var_idx;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ----- sv/bdd_ut_ram.sv -----
`default_nettype none

// simple dual port ram, one write and one registered read per cycle
module bdd_ut_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- sv/bdd_unique_table.sv -----
// S_IDLE takes a key and reads its bucket head, S_HEAD starts the walk or inserts, S_WALK
//   compares chain entries, S_RESULT loads the output register; a new key is taken only
//   in S_IDLE; the single node store read port walks the bucket chain one entry per cycle
// reset: asynchronous, clears the state machine, node count, output valid and all
//   bucket valid bits at once; node store contents need no clearing pass
`default_nettype none

module bdd_unique_table
    import bdd_ut_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // slave side
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // var_index, high_child, low_child
    // master side
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [OUT_DATA_W-1:0] m_tdata,   // node_id
    output logic      [OUT_USER_W-1:0] m_tuser    // created, table_full
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_HEAD   = 4'b0010,
        S_WALK   = 4'b0100,
        S_RESULT = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    // key registers
    logic [VAR_BITS-1:0] var_reg, var_next;
    logic [CHILD_W-1:0]  high_reg, high_next;
    logic [CHILD_W-1:0]  low_reg, low_next;
    bucket_t             bucket_reg, bucket_next;

    // chain state
    logic      head_valid_reg, head_valid_next;
    node_idx_t head_idx_reg, head_idx_next;
    node_idx_t cur_reg, cur_next;

    logic [COUNT_BITS-1:0] used_reg, used_next;
    logic [NUM_BUCKETS-1:0] bvalid_reg, bvalid_next;

    // pending result
    logic [NODE_ID_W-1:0] res_id_reg, res_id_next;
    logic                 res_created_reg, res_created_next;
    logic                 res_full_reg, res_full_next;

    // output register
    logic                 out_valid_reg, out_valid_next;
    logic [NODE_ID_W-1:0] out_id_reg, out_id_next;
    logic                 out_created_reg, out_created_next;
    logic                 out_full_reg, out_full_next;

    // memory ports
    logic      head_we, head_re;
    bucket_t   head_waddr, head_raddr;
    node_idx_t head_wdata, head_rdata;
    logic      ent_we, ent_re;
    node_idx_t ent_waddr, ent_raddr;
    entry_t    ent_wdata, ent_rdata;

    // incoming key fields
    logic [VAR_BITS-1:0] in_var;
    logic [CHILD_W-1:0]  in_high, in_low;
    logic [HASH_W-1:0]   in_hash;
    logic                ent_match;
    logic                store_full;

    assign in_var  = s_tdata[VAR_BITS-1:0];
    assign in_high = s_tdata[VAR_W +: CHILD_W];
    assign in_low  = s_tdata[VAR_W + CHILD_W +: CHILD_W];
    assign in_hash = HASH_W'(in_var) ^ HASH_W'(in_high) ^ HASH_W'(in_low);

    assign ent_match = (ent_rdata.var_idx == var_reg) && (ent_rdata.high == high_reg)
                    && (ent_rdata.low == low_reg);
    assign store_full = (used_reg == COUNT_BITS'(MAX_NODES));

    // bucket head index memory
    bdd_ut_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (NUM_BUCKETS)
    ) u_head_ram (
        .clk   (clk),
        .we    (head_we),
        .waddr (head_waddr),
        .wdata (head_wdata),
        .re    (head_re),
        .raddr (head_raddr),
        .rdata (head_rdata)
    );

    // node store memory
    bdd_ut_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_NODES)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .re    (ent_re),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

    // control and read-modify-write of the chain
    always_comb
    begin
        state_next       = state_reg;
        var_next         = var_reg;
        high_next        = high_reg;
        low_next         = low_reg;
        bucket_next      = bucket_reg;
        head_valid_next  = head_valid_reg;
        head_idx_next    = head_idx_reg;
        cur_next         = cur_reg;
        used_next        = used_reg;
        bvalid_next      = bvalid_reg;
        res_id_next      = res_id_reg;
        res_created_next = res_created_reg;
        res_full_next    = res_full_reg;
        out_valid_next   = out_valid_reg;
        out_id_next      = out_id_reg;
        out_created_next = out_created_reg;
        out_full_next    = out_full_reg;

        s_tready   = 1'b0;
        head_re    = 1'b0;
        head_raddr = BUCKET_BITS'(in_hash);
        head_we    = 1'b0;
        head_waddr = bucket_reg;
        head_wdata = used_reg[ID_BITS-1:0];
        ent_re     = 1'b0;
        ent_raddr  = head_rdata;
        ent_we     = 1'b0;
        ent_waddr  = used_reg[ID_BITS-1:0];
        ent_wdata  = '{next_valid: head_valid_reg, next_idx: head_idx_reg,
                       low: low_reg, high: high_reg, var_idx: var_reg};

        // output register drains independently
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    var_next    = in_var;
                    high_next   = in_high;
                    low_next    = in_low;
                    bucket_next = BUCKET_BITS'(in_hash);
                    head_re     = 1'b1;
                    state_next  = S_HEAD;
                end
            end

            S_HEAD:
            begin
                head_valid_next = bvalid_reg[bucket_reg];
                head_idx_next   = head_rdata;
                if (bvalid_reg[bucket_reg])
                begin
                    ent_re     = 1'b1;
                    ent_raddr  = head_rdata;
                    cur_next   = head_rdata;
                    state_next = S_WALK;
                end
                else
                begin
                    // empty bucket, insert with no successor
                    ent_wdata.next_valid = 1'b0;
                    state_next           = S_RESULT;
                    if (store_full)
                    begin
                        res_id_next      = '0;
                        res_created_next = 1'b0;
                        res_full_next    = 1'b1;
                    end
                    else
                    begin
                        ent_we                  = 1'b1;
                        head_we                 = 1'b1;
                        bvalid_next[bucket_reg] = 1'b1;
                        used_next               = used_reg + 1'b1;
                        res_id_next             = NODE_ID_W'(used_reg[ID_BITS-1:0]);
                        res_created_next        = 1'b1;
                        res_full_next           = 1'b0;
                    end
                end
            end

            S_WALK:
            begin
                if (ent_match)
                begin
                    res_id_next      = NODE_ID_W'(cur_reg);
                    res_created_next = 1'b0;
                    res_full_next    = 1'b0;
                    state_next       = S_RESULT;
                end
                else if (ent_rdata.next_valid)
                begin
                    ent_re    = 1'b1;
                    ent_raddr = ent_rdata.next_idx;
                    cur_next  = ent_rdata.next_idx;
                end
                else
                begin
                    // end of chain, link new node at the head
                    state_next = S_RESULT;
                    if (store_full)
                    begin
                        res_id_next      = '0;
                        res_created_next = 1'b0;
                        res_full_next    = 1'b1;
                    end
                    else
                    begin
                        ent_we                  = 1'b1;
                        head_we                 = 1'b1;
                        bvalid_next[bucket_reg] = 1'b1;
                        used_next               = used_reg + 1'b1;
                        res_id_next             = NODE_ID_W'(used_reg[ID_BITS-1:0]);
                        res_created_next        = 1'b1;
                        res_full_next           = 1'b0;
                    end
                end
            end

            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next   = 1'b1;
                    out_id_next      = res_id_reg;
                    out_created_next = res_created_reg;
                    out_full_next    = res_full_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            bvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            bvalid_reg    <= bvalid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        var_reg         <= var_next;
        high_reg        <= high_next;
        low_reg         <= low_next;
        bucket_reg      <= bucket_next;
        head_valid_reg  <= head_valid_next;
        head_idx_reg    <= head_idx_next;
        cur_reg         <= cur_next;
        res_id_reg      <= res_id_next;
        res_created_reg <= res_created_next;
        res_full_reg    <= res_full_next;
        out_id_reg      <= out_id_next;
        out_created_reg <= out_created_next;
        out_full_reg    <= out_full_next;
    end

    // output transaction
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DATA_W'(out_id_reg);
    assign m_tuser  = {out_full_reg, out_created_reg};

endmodule

`default_nettype wire
